[rtl/ucpt_pkg.sv]
package ucpt_pkg;

    localparam logic [2:0] FORM_UTF8     = 3'd0;
    localparam logic [2:0] FORM_UTF16_BE = 3'd1;
    localparam logic [2:0] FORM_UTF16_LE = 3'd2;
    localparam logic [2:0] FORM_UTF32_BE = 3'd3;
    localparam logic [2:0] FORM_UTF32_LE = 3'd4;

    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_NONCHAR   = 3'd1;
    localparam logic [2:0] ERR_SURROGATE = 3'd2;
    localparam logic [2:0] ERR_RANGE     = 3'd3;
    localparam logic [2:0] ERR_MALFORMED = 3'd4;

    localparam logic [31:0] CP_LIMIT  = 32'h0011_0000;
    localparam logic [20:0] SUPP_BASE = 21'h01_0000;

    typedef struct packed {
        logic        decode;
        logic [2:0]  form;
        logic [31:0] value;
    } ucpt_item_t;

    typedef struct packed {
        logic        decode;
        logic [2:0]  form;
        logic [31:0] value;
        logic [2:0]  err;
    } ucpt_res_t;

    function automatic logic [31:0] swap_units(input logic [31:0] w);
        swap_units = {w[23:16], w[31:24], w[7:0], w[15:8]};
    endfunction

    function automatic logic [31:0] swap_word(input logic [31:0] w);
        swap_word = {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage

[rtl/ucpt_prep.sv]
module ucpt_prep (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  logic                  mode,
    input  logic [31:0]           value_in,
    input  logic [2:0]            form,
    output logic                  valid_reg,
    input  logic                  down_ready,
    output ucpt_pkg::ucpt_item_t  item_reg
);
    import ucpt_pkg::*;

    ucpt_item_t item_next;

    assign up_ready = !valid_reg || down_ready;

    // little-endian decode: undo the byte order before decoding
    always_comb
    begin
        item_next.decode = mode;
        item_next.form   = form;
        item_next.value  = value_in;
        if (mode && (form == FORM_UTF16_LE))
        begin
            item_next.value = swap_units(value_in);
        end
        else if (mode && (form == FORM_UTF32_LE))
        begin
            item_next.value = swap_word(value_in);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

[rtl/ucpt_core.sv]
module ucpt_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  ucpt_pkg::ucpt_item_t  item_in,
    output logic                  valid_reg,
    input  logic                  down_ready,
    output ucpt_pkg::ucpt_res_t   res_reg
);
    import ucpt_pkg::*;

    ucpt_res_t   res_next;
    logic [31:0] v;
    logic        lt_80;
    logic        lt_800;
    logic        lt_10000;
    logic        lt_1000000;
    logic        lt_limit;
    logic        is_nonchar;
    logic        is_surrogate;
    logic [19:0] supp_off;
    logic [20:0] pair_cp;

    assign up_ready = !valid_reg || down_ready;

    assign v            = item_in.value;
    assign lt_80        = (v[31:7] == 25'd0);
    assign lt_800       = (v[31:11] == 21'd0);
    assign lt_10000     = (v[31:16] == 16'd0);
    assign lt_1000000   = (v[31:24] == 8'd0);
    assign lt_limit     = (v < CP_LIMIT);
    assign is_nonchar   = (v[15:1] == 15'h7FFF);
    assign is_surrogate = (v[15:11] == 5'b11011);
    assign supp_off     = v[19:0] - SUPP_BASE[19:0];
    assign pair_cp      = SUPP_BASE + {1'b0, v[25:16], v[9:0]};

    always_comb
    begin
        res_next.decode = item_in.decode;
        res_next.form   = item_in.form;
        res_next.value  = v;
        res_next.err    = ERR_OK;
        unique case (item_in.form)
            FORM_UTF8:
            begin
                if (!item_in.decode)
                begin
                    if (lt_80)
                    begin
                        res_next.value = v;
                    end
                    else if (lt_800)
                    begin
                        res_next.value = {16'd0, 3'b110, v[10:6], 2'b10, v[5:0]};
                    end
                    else if (lt_10000)
                    begin
                        if (is_nonchar)
                        begin
                            res_next.err = ERR_NONCHAR;
                        end
                        else if (is_surrogate)
                        begin
                            res_next.err = ERR_SURROGATE;
                        end
                        res_next.value = {8'd0, 4'b1110, v[15:12], 2'b10, v[11:6],
                                          2'b10, v[5:0]};
                    end
                    else if (lt_limit)
                    begin
                        res_next.value = {5'b11110, v[20:18], 2'b10, v[17:12],
                                          2'b10, v[11:6], 2'b10, v[5:0]};
                    end
                    else
                    begin
                        res_next.err = ERR_RANGE;
                    end
                end
                else
                begin
                    if (lt_80)
                    begin
                        res_next.value = v;
                    end
                    else if (lt_10000)
                    begin
                        if ((v[15:14] != 2'b11) || (v[7] != 1'b1))
                        begin
                            res_next.err = ERR_MALFORMED;
                        end
                        res_next.value = {21'd0, v[12:8], v[5:0]};
                    end
                    else if (lt_1000000)
                    begin
                        if ((v[23:21] != 3'b111) || (v[15] != 1'b1) || (v[7] != 1'b1))
                        begin
                            res_next.err = ERR_MALFORMED;
                        end
                        res_next.value = {16'd0, v[19:16], v[13:8], v[5:0]};
                    end
                    else
                    begin
                        if ((v[31:28] != 4'b1111) || (v[23] != 1'b1) || (v[15] != 1'b1)
                            || (v[7] != 1'b1))
                        begin
                            res_next.err = ERR_MALFORMED;
                        end
                        res_next.value = {11'd0, v[26:24], v[21:16], v[13:8], v[5:0]};
                    end
                end
            end
            FORM_UTF16_BE, FORM_UTF16_LE:
            begin
                if (!item_in.decode)
                begin
                    if (lt_10000)
                    begin
                        if (is_surrogate)
                        begin
                            res_next.err = ERR_SURROGATE;
                        end
                        else if (is_nonchar)
                        begin
                            res_next.err = ERR_NONCHAR;
                        end
                    end
                    else if (lt_limit)
                    begin
                        res_next.value = {6'b110110, supp_off[19:10],
                                          6'b110111, supp_off[9:0]};
                    end
                    else
                    begin
                        res_next.err = ERR_RANGE;
                    end
                end
                else if (!lt_10000)
                begin
                    if ((v[31:30] != 2'b11) || (v[28:27] != 2'b11)
                        || (v[15:14] != 2'b11) || (v[12:10] != 3'b111))
                    begin
                        res_next.err = ERR_MALFORMED;
                    end
                    res_next.value = {11'd0, pair_cp};
                end
            end
            FORM_UTF32_BE, FORM_UTF32_LE:
            begin
                if (is_nonchar)
                begin
                    res_next.err = ERR_NONCHAR;
                end
                else if (!lt_limit)
                begin
                    res_next.err = ERR_RANGE;
                end
            end
            default:
            begin
                res_next.value = v;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            res_reg <= res_next;
        end
    end

endmodule

[rtl/ucpt_pack.sv]
module ucpt_pack (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  ucpt_pkg::ucpt_res_t  res_in,
    output logic                 valid_reg,
    input  logic                 down_ready,
    output logic [31:0]          value_reg,
    output logic [2:0]           err_reg
);
    import ucpt_pkg::*;

    logic [31:0] value_next;

    assign up_ready = !valid_reg || down_ready;

    // errors force zero, little-endian encode swaps the result
    always_comb
    begin
        value_next = res_in.value;
        if (res_in.err != ERR_OK)
        begin
            value_next = 32'd0;
        end
        else if (!res_in.decode && (res_in.form == FORM_UTF16_LE))
        begin
            value_next = swap_units(res_in.value);
        end
        else if (!res_in.decode && (res_in.form == FORM_UTF32_LE))
        begin
            value_next = swap_word(res_in.value);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            value_reg <= value_next;
            err_reg   <= res_in.err;
        end
    end

endmodule

[rtl/unicode_code_point_transcoder_unit.sv]
// three registered stages (byte-order, transcode, pack); out_valid rises once the pack stage
// holds the request, and the result is taken on an edge where out_ready is high
// throughput: one request per cycle unless stalled; each stage holds under back-pressure
// out_ready low stalls the three-stage pipeline without losing or repeating a request
// reset (rst_n low, asynchronous) empties all stages and sets the configured form register to utf8
module unicode_code_point_transcoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  encoding_form,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [31:0] value_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] value_out,
    output logic [2:0]  error_code
);
    import ucpt_pkg::*;

    logic       [2:0] form_reg;
    logic             s1_valid;
    logic             s1_ready;
    ucpt_item_t       s1_item;
    logic             s2_valid;
    logic             s2_ready;
    ucpt_res_t        s2_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            form_reg <= FORM_UTF8;
        end
        else if (cfg_we)
        begin
            form_reg <= encoding_form;
        end
    end

    ucpt_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (in_valid),
        .up_ready   (in_ready),
        .mode       (mode),
        .value_in   (value_in),
        .form       (form_reg),
        .valid_reg  (s1_valid),
        .down_ready (s1_ready),
        .item_reg   (s1_item)
    );

    ucpt_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (s1_valid),
        .up_ready   (s1_ready),
        .item_in    (s1_item),
        .valid_reg  (s2_valid),
        .down_ready (s2_ready),
        .res_reg    (s2_res)
    );

    ucpt_pack u_pack (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (s2_valid),
        .up_ready   (s2_ready),
        .res_in     (s2_res),
        .valid_reg  (out_valid),
        .down_ready (out_ready),
        .value_reg  (value_out),
        .err_reg    (error_code)
    );

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
module testbench;
    import ucpt_pkg::*;

    localparam logic [2:0] FORM_SPARE = 3'd7;
    localparam int PHASES = 10;
    localparam int PHASE_ITEMS = 150;
    localparam int DIR_ROWS = 26;
    localparam logic [2:0] PHASE_FORMS [PHASES] = '{FORM_UTF8, FORM_UTF16_BE, FORM_UTF16_LE,
        FORM_UTF32_BE, FORM_UTF32_LE, FORM_UTF8, FORM_UTF16_LE, FORM_UTF32_LE,
        FORM_UTF16_BE, FORM_UTF32_BE};

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  err;
    } xcode_t;

    typedef struct packed {
        logic [2:0]  form;
        logic        dec;
        logic [31:0] value;
        logic        typed;
        logic [31:0] exp_value;
        logic [2:0]  exp_err;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  encoding_form;
    logic        in_valid;
    logic        in_ready;
    logic        mode;
    logic [31:0] value_in;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] value_out;
    logic [2:0]  error_code;

    xcode_t      pending_results [$];
    logic [2:0]  cur_form = FORM_UTF8;
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    int          hold_count = 0;
    int          mismatch_count = 0;
    dir_row_t    dir_rows [DIR_ROWS];

    unicode_code_point_transcoder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .encoding_form (encoding_form),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .value_in      (value_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .value_out     (value_out),
        .error_code    (error_code)
    );

    function automatic logic [31:0] unit_bswap(input logic [31:0] w);
        return ((w & 32'h00FF_00FF) << 8) | ((w >> 8) & 32'h00FF_00FF);
    endfunction

    function automatic logic [31:0] word_bswap(input logic [31:0] w);
        return {<<8{w}};
    endfunction

    function automatic xcode_t check32(input logic [31:0] c);
        xcode_t r;
        r.value = c;
        r.err = ERR_OK;
        if ((c & 32'hFFFE) == 32'hFFFE)
            r.err = ERR_NONCHAR;
        else if (c >= CP_LIMIT)
            r.err = ERR_RANGE;
        return r;
    endfunction

    function automatic xcode_t transcode(input logic [2:0] form, input logic dec,
                                         input logic [31:0] v);
        xcode_t      r;
        logic [31:0] w;
        logic [31:0] d;
        logic        little;
        r.value = 32'h0;
        r.err = ERR_OK;
        w = 32'h0;
        little = (form == FORM_UTF16_LE);
        case (form)
            FORM_UTF8:
                if (!dec)
                begin
                    if (v < 32'h80)
                        r.value = v;
                    else if (v < 32'h800)
                        r.value = 32'hC080 | ((v & 32'h7C0) << 2) | (v & 32'h3F);
                    else if (v < 32'h10000)
                    begin
                        if ((v & 32'hFFFE) == 32'hFFFE)
                            r.err = ERR_NONCHAR;
                        else if ((v & 32'hF800) == 32'hD800)
                            r.err = ERR_SURROGATE;
                        else
                            r.value = 32'hE08080 | ((v & 32'hF000) << 4)
                                    | ((v & 32'hFC0) << 2) | (v & 32'h3F);
                    end
                    else if (v < CP_LIMIT)
                        r.value = 32'hF0808080 | ((v & 32'h1C0000) << 6)
                                | ((v & 32'h3F000) << 4) | ((v & 32'hFC0) << 2) | (v & 32'h3F);
                    else
                        r.err = ERR_RANGE;
                end
                else
                begin
                    if (v < 32'h80)
                        r.value = v;
                    else if (v < 32'h10000)
                    begin
                        if ((v & 32'hC080) != 32'hC080)
                            r.err = ERR_MALFORMED;
                        else
                            r.value = ((v >> 2) & 32'h7C0) | (v & 32'h3F);
                    end
                    else if (v < 32'h100_0000)
                    begin
                        if ((v & 32'hE08080) != 32'hE08080)
                            r.err = ERR_MALFORMED;
                        else
                            r.value = ((v >> 4) & 32'hF000) | ((v >> 2) & 32'hFC0)
                                    | (v & 32'h3F);
                    end
                    else if ((v & 32'hF0808080) != 32'hF0808080)
                        r.err = ERR_MALFORMED;
                    else
                        r.value = ((v >> 6) & 32'h1C0000) | ((v >> 4) & 32'h3F000)
                                | ((v >> 2) & 32'hFC0) | (v & 32'h3F);
                end
            FORM_UTF16_BE, FORM_UTF16_LE:
                if (!dec)
                begin
                    if (v < 32'h10000)
                    begin
                        if ((v & 32'hF800) == 32'hD800)
                            r.err = ERR_SURROGATE;
                        else if ((v & 32'hFFFE) == 32'hFFFE)
                            r.err = ERR_NONCHAR;
                        else
                            w = v;
                    end
                    else if (v < CP_LIMIT)
                    begin
                        d = v - 32'h10000;
                        w = 32'hD800DC00 | ((d & 32'hFFC00) << 6) | (d & 32'h3FF);
                    end
                    else
                        r.err = ERR_RANGE;
                    r.value = little ? unit_bswap(w) : w;
                end
                else
                begin
                    w = little ? unit_bswap(v) : v;
                    if (w < 32'h10000)
                        r.value = w;
                    else if ((w & 32'hD800DC00) != 32'hD800DC00)
                        r.err = ERR_MALFORMED;
                    else
                        r.value = 32'h10000 + (((w >> 6) & 32'hFFC00) | (w & 32'h3FF));
                end
            FORM_UTF32_BE:
                r = check32(v);
            FORM_UTF32_LE:
                if (dec)
                    r = check32(word_bswap(v));
                else
                begin
                    r = check32(v);
                    r.value = word_bswap(r.value);
                end
            default:
                r.value = v;
        endcase
        if (r.err != ERR_OK)
            r.value = 32'h0;
        return r;
    endfunction

    function automatic logic [31:0] random_code_point();
        case ($urandom_range(11))
            0, 1:    return $urandom_range(32'h7F);
            2, 3:    return $urandom_range(32'h7FF, 32'h80);
            4, 5:    return $urandom_range(32'hFFFF, 32'h800);
            6, 7:    return $urandom_range(32'h10FFFF, 32'h10000);
            8:       return $urandom_range(32'hDFFF, 32'hD800);
            9:       return ($urandom_range(16) << 16) | 32'hFFFE | $urandom_range(1);
            10:      return $urandom_range(32'hFFFF_FFFF, CP_LIMIT);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] random_packed_word(input logic [2:0] form);
        xcode_t enc;
        if ($urandom_range(3) != 0)
        begin
            enc = transcode(form, 1'b0, random_code_point());
            if (enc.err == ERR_OK)
                return ($urandom_range(7) == 0) ? enc.value ^ (32'h1 << $urandom_range(31))
                                                : enc.value;
        end
        return $urandom_range(1) ? $urandom : $urandom_range(32'hFFFF);
    endfunction

    task automatic push_request(input logic dec, input logic [31:0] val, input xcode_t exp);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        mode = dec;
        value_in = val;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(exp);
        @(negedge clk);
    endtask

    task automatic set_form(input logic [2:0] form);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        cfg_we = 1'b1;
        encoding_form = form;
        @(negedge clk);
        cfg_we = 1'b0;
        cur_form = form;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("testbench: errors");
        $finish;
    end

    // receiver side: random stalls plus one long hold-off
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_count > 0)
            begin
                out_ready = 1'b0;
                hold_count--;
            end
            else
                out_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        xcode_t exp;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: value_out %h error_code %0d", value_out, error_code);
                mismatch_count++;
            end
            else
            begin
                exp = pending_results.pop_front();
                if (value_out !== exp.value)
                begin
                    $error("value_out: expected %h, got %h", exp.value, value_out);
                    mismatch_count++;
                end
                if (error_code !== exp.err)
                begin
                    $error("error_code: expected %0d, got %0d", exp.err, error_code);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        logic        dec;
        logic [31:0] val;
        xcode_t      exp;
        int          mix;

        dir_rows = '{
            '{FORM_UTF8,     1'b0, 32'h0000_0000, 1'b1, 32'h0000_0000, ERR_OK},
            '{FORM_UTF8,     1'b0, 32'h0000_007F, 1'b1, 32'h0000_007F, ERR_OK},
            '{FORM_UTF8,     1'b0, 32'h0000_0080, 1'b0, 32'h0, ERR_OK},
            '{FORM_UTF8,     1'b0, 32'h0000_FFFE, 1'b1, 32'h0, ERR_NONCHAR},
            '{FORM_UTF8,     1'b0, 32'h0000_D800, 1'b1, 32'h0, ERR_SURROGATE},
            '{FORM_UTF8,     1'b0, 32'h0010_FFFF, 1'b0, 32'h0, ERR_OK},
            '{FORM_UTF8,     1'b0, 32'h0011_0000, 1'b1, 32'h0, ERR_RANGE},
            '{FORM_UTF8,     1'b0, 32'hFFFF_FFFF, 1'b1, 32'h0, ERR_RANGE},
            '{FORM_UTF8,     1'b1, 32'hF48F_BFBF, 1'b0, 32'h0, ERR_OK},
            '{FORM_UTF8,     1'b1, 32'h0000_FF00, 1'b1, 32'h0, ERR_MALFORMED},
            '{FORM_UTF8,     1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0, ERR_OK},
            '{FORM_UTF8,     1'b1, 32'h0001_FFFF, 1'b1, 32'h0, ERR_MALFORMED},
            '{FORM_UTF16_BE, 1'b0, 32'h0001_0000, 1'b1, 32'hD800_DC00, ERR_OK},
            '{FORM_UTF16_BE, 1'b0, 32'h0000_DFFF, 1'b1, 32'h0, ERR_SURROGATE},
            '{FORM_UTF16_BE, 1'b1, 32'h0000_FFFF, 1'b1, 32'h0000_FFFF, ERR_OK},
            '{FORM_UTF16_BE, 1'b1, 32'h1234_5678, 1'b1, 32'h0, ERR_MALFORMED},
            '{FORM_UTF16_LE, 1'b0, 32'h0010_FFFF, 1'b0, 32'h0, ERR_OK},
            '{FORM_UTF16_LE, 1'b1, 32'h00D8_00DC, 1'b0, 32'h0, ERR_OK},
            '{FORM_UTF32_BE, 1'b0, 32'h0010_FFFE, 1'b1, 32'h0, ERR_NONCHAR},
            '{FORM_UTF32_BE, 1'b1, 32'h0011_0000, 1'b1, 32'h0, ERR_RANGE},
            '{FORM_UTF32_BE, 1'b1, 32'h0010_FFFD, 1'b0, 32'h0, ERR_OK},
            '{FORM_UTF32_LE, 1'b0, 32'h0001_2345, 1'b0, 32'h0, ERR_OK},
            '{FORM_UTF32_LE, 1'b1, 32'hFEFF_0000, 1'b1, 32'h0, ERR_NONCHAR},
            '{FORM_UTF32_LE, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'h0, ERR_NONCHAR},
            '{FORM_SPARE,    1'b0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, ERR_OK},
            '{FORM_SPARE,    1'b1, 32'h0000_0000, 1'b0, 32'h0, ERR_OK}
        };

        rst_n = 1'b0;
        cfg_we = 1'b0;
        encoding_form = FORM_UTF8;
        in_valid = 1'b0;
        mode = 1'b0;
        value_in = 32'h0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].form != cur_form)
                set_form(dir_rows[i].form);
            if (dir_rows[i].typed)
            begin
                exp.value = dir_rows[i].exp_value;
                exp.err = dir_rows[i].exp_err;
            end
            else
                exp = transcode(cur_form, dir_rows[i].dec, dir_rows[i].value);
            push_request(dir_rows[i].dec, dir_rows[i].value, exp);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            set_form(PHASE_FORMS[p]);
            mix = p % 4;
            idle_pct = (mix == 1) ? 63 : (mix == 3) ? 11 : 0;
            stall_pct = (mix == 2) ? 63 : (mix == 3) ? 11 : 0;
            // long receiver hold-off so the pipeline fills and in_ready drops
            if (p == 4)
                hold_count = 80;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                dec = $urandom_range(1);
                val = dec ? random_packed_word(cur_form) : random_code_point();
                push_request(dec, val, transcode(cur_form, dec, val));
            end
        end

        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

[filelist.f]
rtl/ucpt_pkg.sv
rtl/ucpt_prep.sv
rtl/ucpt_core.sv
rtl/ucpt_pack.sv
rtl/unicode_code_point_transcoder_unit.sv
dv/testbench.sv
